FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers shared by the smoother RTL.
// Both check on the rising clock edge and stay quiet while reset is low.

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/hls_pkg.sv
package hls_pkg;

    // Widths of the fixed-point datapath.
    localparam int unsigned QW     = 56;  // Q39.16 level and trend
    localparam int unsigned GW     = 17;  // Q1.16 weights, 65536 means 1.0
    localparam int unsigned SW     = 32;  // integer sample
    localparam int unsigned FRAC   = 16;  // fraction bits of level, trend and weights
    localparam int unsigned CFG_AW = 3;   // byte address of the two config registers

    // Unity weight.
    localparam logic [GW-1:0] Q_ONE = GW'(65536);

    // Configuration register indexes, at byte address 4 * index.
    typedef enum logic {
        REG_LEVEL_GAIN = 1'b0,
        REG_TREND_GAIN = 1'b1
    } t_gain_reg;

    // Smoothing weights as held by the configuration block.
    typedef struct packed {
        logic [GW-1:0] level_gain;
        logic [GW-1:0] trend_gain;
    } t_gains;

    // Request into the shared weighting unit.
    typedef struct packed {
        logic                 go;
        logic signed [QW-1:0] opnd;
        logic [GW-1:0]        gain;
    } t_weigh_req;

    // Response from the shared weighting unit.
    typedef struct packed {
        logic               done;
        logic signed [QW:0] value;
    } t_weigh_rsp;

endpackage

FILE: rtl/hls_cfg.sv
module hls_cfg
    import hls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_gains            o_gains
);

    localparam logic [GW-1:0] GAIN_RESET = GW'(32768);

    logic [GW-1:0] r_level_gain;
    logic [GW-1:0] r_trend_gain;
    logic [GW-1:0] w_wval;
    logic          w_wr;
    t_gain_reg     w_idx;

    // Weights above one are taken as one.
    assign w_wval = (pwdata[GW-1:0] > Q_ONE) ? Q_ONE : pwdata[GW-1:0];
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_gain_reg'(paddr[CFG_AW-1]);
    assign pready = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_gain <= GAIN_RESET;
            r_trend_gain <= GAIN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LEVEL_GAIN: r_level_gain <= w_wval;
                REG_TREND_GAIN: r_trend_gain <= w_wval;
                default:        r_level_gain <= r_level_gain;
            endcase
        end
    end

    // Read-back of the stored weights.
    always_comb begin
        unique case (w_idx)
            REG_LEVEL_GAIN: prdata = 32'(r_level_gain);
            REG_TREND_GAIN: prdata = 32'(r_trend_gain);
            default:        prdata = '0;
        endcase
    end

    assign o_gains.level_gain = r_level_gain;
    assign o_gains.trend_gain = r_trend_gain;

endmodule

FILE: rtl/hls_weigh.sv
`include "assert_macros.svh"

module hls_weigh
    import hls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_weigh_req i_req,
    output t_weigh_rsp o_rsp
);

    // The magnitude is split into a fraction chunk and two integer chunks so that
    // a single 24 x 17 multiplier covers the whole 56-bit operand in three passes.
    localparam int unsigned CW    = 24;
    localparam int unsigned PW    = CW + GW;
    localparam int unsigned TOP_W = QW - FRAC - CW;
    localparam int unsigned ROUND = 1 << (FRAC - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_MID,
        ST_TOP,
        ST_ADD,
        ST_DONE
    } t_state;

    t_state          r_state;
    logic            r_neg;
    logic [QW-1:0]   r_mag;
    logic [GW-1:0]   r_gain;
    logic [PW-1:0]   r_prod;
    logic [QW-1:0]   r_acc;
    logic [QW-1:0]   w_mag;
    logic [CW-1:0]   w_chunk;
    logic [PW-1:0]   w_prod;

    // Magnitude of the incoming operand.
    assign w_mag = i_req.opnd[QW-1] ? (~i_req.opnd + QW'(1)) : i_req.opnd;

    // Chunk of the magnitude that feeds the multiplier in each pass.
    always_comb begin
        case (r_state)
            ST_LO:   w_chunk = CW'(r_mag[FRAC-1:0]);
            ST_MID:  w_chunk = r_mag[FRAC+CW-1:FRAC];
            ST_TOP:  w_chunk = CW'(r_mag[FRAC+CW+TOP_W-1:FRAC+CW]);
            default: w_chunk = '0;
        endcase
    end

    assign w_prod = PW'(w_chunk) * PW'(r_gain);

    // Sequencer: multiply one chunk per cycle, accumulate the previous product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.go) begin
                        r_neg   <= i_req.opnd[QW-1];
                        r_mag   <= w_mag;
                        r_gain  <= i_req.gain;
                        r_state <= ST_LO;
                    end
                end
                ST_LO: begin
                    r_prod  <= w_prod;
                    r_state <= ST_MID;
                end
                ST_MID: begin
                    // Fraction part, rounded to nearest with ties away from zero.
                    r_acc   <= QW'((r_prod + PW'(ROUND)) >> FRAC);
                    r_prod  <= w_prod;
                    r_state <= ST_TOP;
                end
                ST_TOP: begin
                    r_acc   <= r_acc + QW'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    // The top chunk sits CW bits above the middle one in the integer part.
                    r_acc   <= r_acc + (QW'(r_prod) << CW);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // The sign is applied back to the rounded magnitude.
    assign o_rsp.done  = (r_state == ST_DONE);
    assign o_rsp.value = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});

    // A new request only arrives while the unit is free.
    `ASSERT_IMP(a_go_when_idle, i_clk, i_rst_n, i_req.go, r_state == ST_IDLE)
    // Completion is a single-cycle pulse.
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_rsp.done, !o_rsp.done)

endmodule

FILE: rtl/holt_linear_smoother.sv
// Holt linear smoother: takes integer samples grouped into series by start and end
// marks and tracks a level and a trend in signed Q39.16, saturated to that range.
// The first sample of a series loads both level and trend with the sample; every
// other sample updates level = a*x + (1-a)*(level+trend), then
// trend = b*(new level - level) + (1-b)*trend, with a and b the Q1.16 weights
// written over the APB port (register 0 at address 0, register 1 at address 4,
// values above 65536 taken as 65536). A result with the final level and trend is
// produced on the sample that carries the end mark. A start sample goes straight
// to the final step; any other sample takes four passes through the single
// shared weighting unit, each pass three multiplies on one 24 x 17 multiplier
// plus rounding and sign handling. A result waits in an output register; the block
// still takes the next sample, and only holds before delivering another result
// while the previous one has not been taken.

`include "assert_macros.svh"

module holt_linear_smoother
    import hls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [SW-1:0] i_sample,
    input  logic                 i_series_start,
    input  logic                 i_series_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [QW-1:0] o_final_level,
    output logic signed [QW-1:0] o_final_trend
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_W1,
        S_W2,
        S_DIFF,
        S_W3,
        S_W4,
        S_FIN
    } t_state;

    t_state               r_state;
    logic signed [QW-1:0] r_level;
    logic signed [QW-1:0] r_trend;
    logic signed [QW-1:0] r_sum;
    logic signed [QW-1:0] r_nl;
    logic signed [QW:0]   r_w;
    logic signed [QW-1:0] r_opnd;
    logic [GW-1:0]        r_gain;
    logic                 r_go;
    logic                 r_end;
    logic                 r_out_valid;
    logic signed [QW-1:0] r_out_level;
    logic signed [QW-1:0] r_out_trend;
    logic                 n_go;
    logic                 n_out_valid;
    logic                 w_load;
    logic                 w_start_xfer;
    logic                 w_in_wait;
    logic signed [QW-1:0] w_x;
    t_gains               w_gains;
    t_weigh_req           w_req;
    t_weigh_rsp           w_rsp;

    // Saturate a two-bit-wider sum to Q39.16.
    function automatic logic signed [QW-1:0] f_sat(input logic signed [QW+1:0] v);
        logic signed [QW-1:0] res;
        if (v[QW+1:QW-1] == 3'b000 || v[QW+1:QW-1] == 3'b111) begin
            res = v[QW-1:0];
        end else if (v[QW+1]) begin
            res = {1'b1, {(QW-1){1'b0}}};
        end else begin
            res = {1'b0, {(QW-1){1'b1}}};
        end
        return res;
    endfunction

    hls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (w_gains)
    );

    assign w_req.go   = r_go;
    assign w_req.opnd = r_opnd;
    assign w_req.gain = r_gain;

    hls_weigh u_weigh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Integer sample moved into Q39.16.
    assign w_x = {{(QW-SW-FRAC){i_sample[SW-1]}}, i_sample, FRAC'(0)};

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_final_level = r_out_level;
    assign o_final_trend = r_out_trend;

    // A request goes to the weighting unit when each weighted term is ready to start.
    assign n_go = (r_state == S_IDLE && i_in_valid && !i_series_start) ||
                  (r_state == S_W1 && w_rsp.done) ||
                  (r_state == S_DIFF) ||
                  (r_state == S_W3 && w_rsp.done);

    // The output register is loaded at the end of a series once it is free or draining.
    assign w_load      = (r_state == S_FIN) && r_end && (!r_out_valid || i_out_ready);
    assign n_out_valid = w_load || (r_out_valid && !i_out_ready);

    // Sequencer over the four weighted terms of one update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_trend     <= '0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_end <= i_series_end;
                        if (i_series_start) begin
                            r_level <= w_x;
                            r_trend <= w_x;
                            r_state <= S_FIN;
                        end else begin
                            r_sum   <= f_sat((QW+2)'(r_level) + (QW+2)'(r_trend));
                            r_opnd  <= w_x;
                            r_gain  <= w_gains.level_gain;
                            r_state <= S_W1;
                        end
                    end
                end
                S_W1: begin
                    if (w_rsp.done) begin
                        r_w     <= w_rsp.value;
                        r_opnd  <= r_sum;
                        r_gain  <= Q_ONE - w_gains.level_gain;
                        r_state <= S_W2;
                    end
                end
                S_W2: begin
                    if (w_rsp.done) begin
                        r_nl    <= f_sat((QW+2)'(r_w) + (QW+2)'(w_rsp.value));
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_opnd  <= f_sat((QW+2)'(r_nl) - (QW+2)'(r_level));
                    r_gain  <= w_gains.trend_gain;
                    r_state <= S_W3;
                end
                S_W3: begin
                    if (w_rsp.done) begin
                        r_w     <= w_rsp.value;
                        r_opnd  <= r_trend;
                        r_gain  <= Q_ONE - w_gains.trend_gain;
                        r_state <= S_W4;
                    end
                end
                S_W4: begin
                    if (w_rsp.done) begin
                        r_level <= r_nl;
                        r_trend <= f_sat((QW+2)'(r_w) + (QW+2)'(w_rsp.value));
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Load the output register once it is free or being drained.
                    if (!r_end) begin
                        r_state <= S_IDLE;
                    end else if (w_load) begin
                        r_out_level <= r_level;
                        r_out_trend <= r_trend;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_start_xfer = i_in_valid && o_in_ready && i_series_start;
    assign w_in_wait    = (r_state == S_W1) || (r_state == S_W2) ||
                          (r_state == S_W3) || (r_state == S_W4);

    // A start sample loads level and trend with the same value in one step.
    `ASSERT_NEXT(a_start_load, i_clk, i_rst_n, w_start_xfer, r_state == S_FIN && r_level == r_trend)
    // Requests to the weighting unit are only issued while waiting on it.
    `ASSERT_IMP(a_go_in_wait, i_clk, i_rst_n, r_go, w_in_wait)

endmodule

FILE: dv/tb_holt_linear_smoother.sv
// Level and trend pair reported at the end of a series.
typedef struct packed {
    logic signed [hls_pkg::QW-1:0] final_level;
    logic signed [hls_pkg::QW-1:0] final_trend;
} smoother_out_t;

// Tracks the expected level and trend and checks every result against them.
class holt_tracker;
    localparam longint LEVEL_MAX = 64'sd36028797018963967;
    localparam longint LEVEL_MIN = -LEVEL_MAX - 1;
    localparam int unsigned UNITY = 65536;

    int unsigned   level_gain;
    int unsigned   trend_gain;
    longint        level;
    longint        trend;
    smoother_out_t expected_states[$];
    int            errors;

    function new();
        level_gain = UNITY / 2;
        trend_gain = UNITY / 2;
        level      = 0;
        trend      = 0;
        errors     = 0;
    endfunction

    function longint saturate_q(longint v);
        if (v > LEVEL_MAX) return LEVEL_MAX;
        if (v < LEVEL_MIN) return LEVEL_MIN;
        return v;
    endfunction

    // Scale by a Q1.16 weight, rounding to nearest with ties away from zero.
    function longint apply_gain(longint v, int unsigned g);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? -v : v;
        r = (mag >> 16) * g + (((mag & 64'hFFFF) * g + 64'd32768) >> 16);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Only the low 17 bits are kept, and anything above unity is taken as unity.
    function void set_gain(int idx, logic [31:0] raw);
        int unsigned g;
        g = raw[16:0];
        if (g > UNITY) g = UNITY;
        if (idx == hls_pkg::REG_LEVEL_GAIN) level_gain = g;
        else if (idx == hls_pkg::REG_TREND_GAIN) trend_gain = g;
    endfunction

    // Advance the level and trend by one accepted sample.
    function void take_sample(logic signed [31:0] s, logic first, logic last);
        longint x;
        longint sum;
        longint nl;
        longint d;
        longint nt;
        smoother_out_t res;
        x = longint'(s) * 64'sd65536;
        if (first) begin
            level = x;
            trend = x;
        end else begin
            sum   = saturate_q(level + trend);
            nl    = saturate_q(apply_gain(x, level_gain) + apply_gain(sum, UNITY - level_gain));
            d     = saturate_q(nl - level);
            nt    = saturate_q(apply_gain(d, trend_gain) + apply_gain(trend, UNITY - trend_gain));
            level = nl;
            trend = nt;
        end
        if (last) begin
            res.final_level = 56'(level);
            res.final_trend = 56'(trend);
            expected_states.push_back(res);
        end
    endfunction

    // Compare one delivered result with the oldest expected one.
    function void compare_output(logic signed [55:0] lv, logic signed [55:0] tr);
        smoother_out_t want;
        if (expected_states.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: level %0d trend %0d", lv, tr);
        end else begin
            want = expected_states.pop_front();
            if (want.final_level !== lv || want.final_trend !== tr) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: level exp %0d got %0d, trend exp %0d got %0d",
                             want.final_level, lv, want.final_trend, tr);
            end
        end
    endfunction

    function int pending();
        return expected_states.size();
    endfunction
endclass

module tb_holt_linear_smoother;
    import hls_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAMP_STEPS   = 261;
    localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAMPLE_MIN = 32'sh80000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [SW-1:0] i_sample;
    logic                 i_series_start;
    logic                 i_series_end;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [QW-1:0] o_final_level;
    logic signed [QW-1:0] o_final_trend;

    holt_tracker tracker = new();
    bit          calm;
    int          stall_left;
    int          roll;
    int          cycles;

    holt_linear_smoother i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_series_start (i_series_start),
        .i_series_end   (i_series_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_final_level  (o_final_level),
        .o_final_trend  (o_final_trend)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watch both channels; every transfer goes to the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            tracker.take_sample(i_sample, i_series_start, i_series_end);
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.compare_output(o_final_level, o_final_trend);
    end

    // Result side backpressure: mostly ready, with short and occasional long stalls.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                i_out_ready <= 1'b1;
            end else if (roll < 95) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(9, 59);
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[holt_linear_smoother] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly full-range values, with extremes and values near zero mixed in.
    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 15))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return '1;
            4: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // Present one sample and hold it until the transfer; valid drops only before a gap.
    task automatic send_sample(input logic signed [31:0] s, input logic first,
                               input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample       <= s;
        i_series_start <= first;
        i_series_end   <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Let every expected result arrive, then give a sample without an end mark
    // time to finish inside the block.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both weight registers back to back over the APB port.
    task automatic write_gains(input logic [31:0] level_val, input logic [31:0] trend_val);
        logic [31:0] vals [2];
        vals[REG_LEVEL_GAIN] = level_val;
        vals[REG_TREND_GAIN] = trend_val;
        psel   <= 1'b1;
        pwrite <= 1'b1;
        for (int r = REG_LEVEL_GAIN; r <= REG_TREND_GAIN; r++) begin
            penable <= 1'b0;
            paddr   <= CFG_AW'(4 * r);
            pwdata  <= vals[r];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            tracker.set_gain(r, vals[r]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A long series that walks the level into saturation; end marks along the way
    // report it without restarting the series.
    task automatic run_ramp(input logic signed [31:0] seed_sample);
        send_sample(seed_sample, 1'b1, 1'b0);
        for (int k = 1; k <= RAMP_STEPS; k++)
            send_sample(pick_sample(), 1'b0, (k % 32 == 0) || (k == RAMP_STEPS));
    endtask

    // Mostly well-formed series of random length, the rest loose samples with random marks.
    task automatic run_random_phase(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 80) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    send_sample(pick_sample(), k == 0, k == len - 1);
                sent += len;
            end else begin
                send_sample(pick_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_sample       <= '0;
        i_series_start <= 1'b0;
        i_series_end   <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset weights.
        // A sample with no series open after reset updates from zero.
        send_sample(32'sd1000, 1'b0, 1'b1);
        // Single-sample series at the extremes of the sample range and at zero.
        send_sample(SAMPLE_MAX, 1'b1, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1, 1'b1);
        send_sample(32'sd0, 1'b1, 1'b1);
        // An ordinary series.
        send_sample(-32'sd1, 1'b1, 1'b0);
        send_sample(32'sd5, 1'b0, 1'b0);
        send_sample(-32'sd7, 1'b0, 1'b0);
        send_sample(32'sd12, 1'b0, 1'b1);
        // After the end, a sample without a start continues from the kept state.
        send_sample(32'sd3, 1'b0, 1'b1);
        // A start in mid-series restarts it.
        send_sample(32'sd10, 1'b1, 1'b0);
        send_sample(32'sd20, 1'b0, 1'b0);
        send_sample(-32'sd30, 1'b1, 1'b0);
        send_sample(32'sd40, 1'b0, 1'b1);
        // Full-scale swings.
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0, 1'b1);
        settle();

        // Zero level weight and unity trend weight make the level grow by the trend
        // each sample, which drives it into saturation in both directions.
        write_gains(32'd0, 32'd65536);
        run_ramp(SAMPLE_MAX);
        run_ramp(SAMPLE_MIN);
        settle();

        // Random phases, the weight extremes first, including values above unity.
        for (int p = 0; p < 6; p++) begin
            calm = ($urandom_range(0, 3) == 0);
            case (p)
                0: write_gains(32'h1FFFF, 32'd0);
                1: write_gains(32'hFFFFFFFF, 32'd65535);
                2: write_gains(32'd1, 32'h20005);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        write_gains($urandom, $urandom_range(0, 65536));
                    else
                        write_gains($urandom_range(0, 65536), $urandom_range(0, 65536));
                end
            endcase
            run_random_phase(4);
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("[holt_linear_smoother] OK");
        else
            $display("[holt_linear_smoother] ERROR");
        $finish;
    end

endmodule
